FILE: hw/rtl/segc_pkg.sv
// segc_pkg: shared types, constants and step functions for the exposure and gain block
// used by sensor_exposure_gain_calc_core and its port checker
// no dependencies
package segc_pkg;

   // field widths
   localparam int unsigned REQ_W        = 24;
   localparam int unsigned FRAME_W      = 23;
   localparam int unsigned MIN_EXP_W    = 16;
   localparam int unsigned STEP_W       = 8;
   localparam int unsigned REG_W        = 16;
   localparam int unsigned SHIFT_W      = 3;
   localparam int unsigned CODE_W       = 10;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned CSR_ADDR_W   = 4;

   // reset values of the control registers
   localparam logic [FRAME_W-1:0]   DEFAULT_FRAME_RST = 23'd2494;
   localparam logic [FRAME_W-1:0]   MIN_FRAME_RST     = 23'd1336;
   localparam logic [MIN_EXP_W-1:0] MIN_EXP_RST       = 16'd4;
   localparam logic [STEP_W-1:0]    EXP_STEP_RST      = 8'd2;

   // arithmetic constants
   localparam logic [REQ_W-1:0]   FRAME_REG_MAX = 24'd65535;
   localparam logic [FRAME_W-1:0] EXP_MARGIN    = 23'd48;
   localparam logic [CODE_W-1:0]  CODE_MIN      = 10'd112;
   localparam logic [CODE_W-1:0]  CODE_MAX      = 10'd960;
   localparam logic [REG_W-1:0]   DIG_MIN       = 16'd256;
   localparam logic [10:0]        CODE_FULL     = 11'd1024;

   // reciprocal: ceil(2^26/gain) >= 912 when 911*gain < 2^26,
   // and <= 64 when gain >= 2^20; only the range between is divided
   localparam int unsigned RCP_NUM_W    = 27;
   localparam int unsigned RCP_DIV_W    = 20;
   localparam int unsigned RCP_CMP_W    = 29;
   localparam logic [RCP_NUM_W-1:0] RCP_NUM = 27'h400_0000;
   localparam logic [33:0] RCP_LOW_THR  = 34'h400_0000;
   localparam logic [33:0] RCP_LOW_MUL  = 34'd911;

   // pipeline shape
   localparam int unsigned MID_STAGES   = 8;
   localparam int unsigned MOD_BITS     = 3;
   localparam int unsigned EXP_PAD_W    = MID_STAGES * MOD_BITS;
   localparam int unsigned LATENCY      = 13;

   typedef enum logic [1:0] {
      CSR_DEFAULT_FRAME = 2'd0,
      CSR_MIN_FRAME     = 2'd1,
      CSR_MIN_EXPOSURE  = 2'd2,
      CSR_EXPOSURE_STEP = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  bad;
      logic [SHIFT_W-1:0]    shift;
      logic [FRAME_W-1:0]    frame;
      logic [REG_W-1:0]      frame_reg;
      logic [FRAME_W-1:0]    eff_frame;
      logic [FRAME_W-1:0]    exp_hi;
      logic [REQ_W-1:0]      req_exp;
      logic [FRAME_W-1:0]    exp;
      logic [STEP_W-1:0]     exp_rem;
      logic [REQ_W-1:0]      gain;
      logic                  code_min_sat;
      logic                  code_max_sat;
      logic [RCP_NUM_W-1:0]  rcp_rem;
      logic [CODE_W-1:0]     rcp_quo;
      logic [CODE_W-1:0]     code;
      logic [REG_W-1:0]      exp_reg;
   } pipe_type;

   typedef struct packed {
      logic                 take;
      logic [RCP_NUM_W-1:0] rem;
   } rcp_step_type;

   // one restoring step of the reciprocal divide at quotient bit k
   function automatic rcp_step_type rcp_step(input logic [RCP_NUM_W-1:0] rem,
                                             input logic [RCP_DIV_W-1:0] div,
                                             input int unsigned k);
      logic [RCP_CMP_W-1:0] d;
      rcp_step_type         r;
      d      = {9'b0, div} << k;
      r.take = ({2'b0, rem} >= d);
      r.rem  = r.take ? (rem - d[RCP_NUM_W-1:0]) : rem;
      return r;
   endfunction

   // one bit of the exposure modulo; r is always below step
   function automatic logic [STEP_W-1:0] mod_step(input logic [STEP_W-1:0] r,
                                                  input logic b,
                                                  input logic [STEP_W-1:0] step);
      logic [STEP_W:0] t;
      t = {r, b};
      if (t >= {1'b0, step}) begin
         t = t - {1'b0, step};
      end
      return t[STEP_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/sensor_exposure_gain_calc_core.sv
// sensor_exposure_gain_calc_core: converts frame, exposure and gain requests to sensor codes
// depends on segc_pkg
//
// usage:
//   a request transaction is taken at each rising edge where start is high and busy is low;
//   busy never rises, so a new request may follow in every cycle
//   each request produces exactly one result transaction, shown on the rsp_ ports for one
//   cycle with rsp_valid high; results keep request order
//   the receiver cannot stall, so every pipeline stage advances on every clock
//   throughput is one request per cycle; latency is set by the 10-step reciprocal divide and
//   the 24-bit exposure modulo, three bits per stage, which run side by side in 8 middle stages
//   the csr_ port is APB style: register i at byte address 4*i, writes complete in the access
//   cycle, pready is tied high; registers are meant to change only while no request is in flight
//   reset (synchronous, active high) clears all stage valid bits and restores the
//   default register values; no memory needs clearing
//
// stages:
//   1 frame select, error check, shift search, gain range flags, divide numerator
//   2 frame register value, effective frame, exposure upper bound
//   3 exposure clamp, reciprocal quotient bit 9
//   4..11 exposure modulo (3 bits each), reciprocal quotient bits 8..1
//   12 quotient bit 0, analog code, rounded and shifted exposure
//   13 digital gain multiply and clamp into the result registers
module sensor_exposure_gain_calc_core
   import segc_pkg::*;
#(
   parameter int unsigned MAX_FRAME_SHIFT = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [REQ_W-1:0]      req_frame_lines_req,
   input  logic [REQ_W-1:0]      req_exposure_lines_req,
   input  logic [REQ_W-1:0]      req_total_gain_q16,
   // result channel
   output logic                  rsp_valid,
   output logic                  rsp_bad_request,
   output logic [REG_W-1:0]      rsp_frame_reg_value,
   output logic [SHIFT_W-1:0]    rsp_frame_shift,
   output logic [REG_W-1:0]      rsp_exposure_reg_value,
   output logic [CODE_W-1:0]     rsp_analog_gain_code,
   output logic [REG_W-1:0]      rsp_digital_gain_code,
   output logic [FRAME_W-1:0]    rsp_effective_frame_lines,
   output logic [FRAME_W-1:0]    rsp_effective_exposure_lines,
   // control registers
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // largest frame accepted, 65535 << MAX_FRAME_SHIFT
   localparam logic [REQ_W-1:0] MAX_FRAME = REQ_W'(FRAME_REG_MAX << MAX_FRAME_SHIFT);

   // ---------------------------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------------------------
   logic [FRAME_W-1:0]   default_frame_ff;
   logic [FRAME_W-1:0]   min_frame_ff;
   logic [MIN_EXP_W-1:0] min_exp_ff;
   logic [STEP_W-1:0]    exp_step_ff;
   csr_index_type        csr_idx;
   logic                 csr_wr;

   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_frame_ff <= DEFAULT_FRAME_RST;
         min_frame_ff     <= MIN_FRAME_RST;
         min_exp_ff       <= MIN_EXP_RST;
         exp_step_ff      <= EXP_STEP_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_DEFAULT_FRAME: default_frame_ff <= csr_pwdata[FRAME_W-1:0];
            CSR_MIN_FRAME:     min_frame_ff     <= csr_pwdata[FRAME_W-1:0];
            CSR_MIN_EXPOSURE:  min_exp_ff       <= csr_pwdata[MIN_EXP_W-1:0];
            CSR_EXPOSURE_STEP: exp_step_ff      <= csr_pwdata[STEP_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_DEFAULT_FRAME: csr_prdata = {9'b0, default_frame_ff};
         CSR_MIN_FRAME:     csr_prdata = {9'b0, min_frame_ff};
         CSR_MIN_EXPOSURE:  csr_prdata = {16'b0, min_exp_ff};
         CSR_EXPOSURE_STEP: csr_prdata = {24'b0, exp_step_ff};
      endcase
   end

   // a zero step means no rounding
   logic [STEP_W-1:0] step_eff;
   assign step_eff = (exp_step_ff == '0) ? STEP_W'(1) : exp_step_ff;

   // the pipeline never stalls
   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // ---------------------------------------------------------------------------------------
   // stage 1: frame select, error check, shift search, gain range flags
   // ---------------------------------------------------------------------------------------
   pipe_type s1_in, s1_ff;
   logic     s1_vld_ff;

   always_comb begin
      logic [REQ_W-1:0] frame24;
      logic [33:0]      gain_x911;
      s1_in     = '0;
      frame24   = (req_frame_lines_req != '0) ? req_frame_lines_req
                                              : {1'b0, default_frame_ff};
      gain_x911 = 34'(req_total_gain_q16) * RCP_LOW_MUL;
      s1_in.bad = (req_total_gain_q16 == '0) || (frame24 < {1'b0, min_frame_ff}) ||
                  (frame24 > MAX_FRAME);
      // smallest shift that brings the frame into 16 bits
      for (int k = 1; k <= MAX_FRAME_SHIFT; k++) begin
         if ((frame24 >> (k - 1)) > FRAME_REG_MAX) begin
            s1_in.shift = SHIFT_W'(k);
         end
      end
      s1_in.frame        = frame24[FRAME_W-1:0];
      s1_in.req_exp      = req_exposure_lines_req;
      s1_in.gain         = req_total_gain_q16;
      s1_in.code_min_sat = (gain_x911 < RCP_LOW_THR);
      s1_in.code_max_sat = (req_total_gain_q16[REQ_W-1:RCP_DIV_W] != '0);
      // numerator for the rounded-up reciprocal
      s1_in.rcp_rem      = RCP_NUM + RCP_NUM_W'(req_total_gain_q16) - RCP_NUM_W'(1);
   end

   // ---------------------------------------------------------------------------------------
   // stage 2: frame register value, effective frame, exposure upper bound
   // ---------------------------------------------------------------------------------------
   pipe_type s2_in, s2_ff;
   logic     s2_vld_ff;

   always_comb begin
      s2_in           = s1_ff;
      s2_in.frame_reg = REG_W'(s1_ff.frame >> s1_ff.shift);
      s2_in.eff_frame = {7'b0, s2_in.frame_reg} << s1_ff.shift;
      s2_in.exp_hi    = (s2_in.eff_frame >= EXP_MARGIN) ? (s2_in.eff_frame - EXP_MARGIN) : '0;
   end

   // ---------------------------------------------------------------------------------------
   // stage 3: exposure clamp, first quotient bit
   // ---------------------------------------------------------------------------------------
   pipe_type s3_in, s3_ff;
   logic     s3_vld_ff;

   always_comb begin
      rcp_step_type rs;
      s3_in = s2_ff;
      if (s2_ff.req_exp < {8'b0, min_exp_ff}) begin
         s3_in.exp = {7'b0, min_exp_ff};
      end else if ({1'b0, s2_ff.exp_hi} < s2_ff.req_exp) begin
         s3_in.exp = s2_ff.exp_hi;
      end else begin
         s3_in.exp = s2_ff.req_exp[FRAME_W-1:0];
      end
      s3_in.exp_rem    = '0;
      rs               = rcp_step(s2_ff.rcp_rem, s2_ff.gain[RCP_DIV_W-1:0], CODE_W - 1);
      s3_in.rcp_rem    = rs.rem;
      s3_in.rcp_quo    = '0;
      s3_in.rcp_quo[CODE_W-1] = rs.take;
   end

   // ---------------------------------------------------------------------------------------
   // stages 4..11: exposure modulo three bits a stage, one quotient bit a stage
   // ---------------------------------------------------------------------------------------
   pipe_type                mid_in [MID_STAGES];
   pipe_type                mid_ff [MID_STAGES];
   pipe_type                mid_src[MID_STAGES];
   logic [MID_STAGES-1:0]   mid_vld_ff;
   logic [MID_STAGES-1:0]   mid_vld_src;

   for (genvar i = 0; i < MID_STAGES; i++) begin : g_mid
      if (i == 0) begin : g_first
         assign mid_src[i]     = s3_ff;
         assign mid_vld_src[i] = s3_vld_ff;
      end else begin : g_next
         assign mid_src[i]     = mid_ff[i-1];
         assign mid_vld_src[i] = mid_vld_ff[i-1];
      end

      always_comb begin
         logic [EXP_PAD_W-1:0] e_pad;
         logic [STEP_W-1:0]    r;
         rcp_step_type         rs;
         mid_in[i] = mid_src[i];
         e_pad     = EXP_PAD_W'(mid_src[i].exp);
         r         = mid_src[i].exp_rem;
         for (int j = 0; j < MOD_BITS; j++) begin
            r = mod_step(r, e_pad[EXP_PAD_W - 1 - MOD_BITS * i - j], step_eff);
         end
         mid_in[i].exp_rem = r;
         rs = rcp_step(mid_src[i].rcp_rem, mid_src[i].gain[RCP_DIV_W-1:0], CODE_W - 2 - i);
         mid_in[i].rcp_rem = rs.rem;
         mid_in[i].rcp_quo[CODE_W - 2 - i] = rs.take;
      end

      always_ff @(posedge clock) begin
         mid_ff[i] <= mid_in[i];
         if (reset) begin
            mid_vld_ff[i] <= 1'b0;
         end else begin
            mid_vld_ff[i] <= mid_vld_src[i];
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 12: last quotient bit, analog code, rounded and shifted exposure
   // ---------------------------------------------------------------------------------------
   pipe_type s12_in, s12_ff;
   logic     s12_vld_ff;

   always_comb begin
      rcp_step_type       rs;
      logic [CODE_W-1:0]  quo;
      logic [FRAME_W-1:0] exp_rnd;
      logic [FRAME_W-1:0] exp_shr;
      s12_in  = mid_ff[MID_STAGES-1];
      rs      = rcp_step(mid_ff[MID_STAGES-1].rcp_rem,
                         mid_ff[MID_STAGES-1].gain[RCP_DIV_W-1:0], 0);
      quo     = {mid_ff[MID_STAGES-1].rcp_quo[CODE_W-1:1], rs.take};
      s12_in.rcp_rem = rs.rem;
      s12_in.rcp_quo = quo;
      if (mid_ff[MID_STAGES-1].code_min_sat) begin
         s12_in.code = CODE_MIN;
      end else if (mid_ff[MID_STAGES-1].code_max_sat) begin
         s12_in.code = CODE_MAX;
      end else begin
         s12_in.code = CODE_W'(CODE_FULL - {1'b0, quo});
      end
      exp_rnd = mid_ff[MID_STAGES-1].exp - FRAME_W'(mid_ff[MID_STAGES-1].exp_rem);
      exp_shr = exp_rnd >> mid_ff[MID_STAGES-1].shift;
      s12_in.exp_reg = (exp_shr[REG_W-1:0] == '0) ? REG_W'(1) : exp_shr[REG_W-1:0];
   end

   // ---------------------------------------------------------------------------------------
   // stage registers 1..3 and 12
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      s12_ff <= s12_in;
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s12_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= accept;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s12_vld_ff <= mid_vld_ff[MID_STAGES-1];
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 13: digital gain and result registers
   // ---------------------------------------------------------------------------------------
   logic                 rsp_valid_ff;
   logic                 rsp_bad_ff,       rsp_bad_in;
   logic [REG_W-1:0]     rsp_frame_reg_ff, rsp_frame_reg_in;
   logic [SHIFT_W-1:0]   rsp_shift_ff,     rsp_shift_in;
   logic [REG_W-1:0]     rsp_exp_reg_ff,   rsp_exp_reg_in;
   logic [CODE_W-1:0]    rsp_code_ff,      rsp_code_in;
   logic [REG_W-1:0]     rsp_dig_ff,       rsp_dig_in;
   logic [FRAME_W-1:0]   rsp_eff_frame_ff, rsp_eff_frame_in;
   logic [FRAME_W-1:0]   rsp_eff_exp_ff,   rsp_eff_exp_in;

   always_comb begin
      logic [CODE_W-1:0] code_rest;
      logic [33:0]       prod;
      logic [REG_W-1:0]  dig;
      code_rest = CODE_W'(CODE_FULL - {1'b0, s12_ff.code});
      prod      = 34'(s12_ff.gain) * 34'(code_rest);
      // the product stays below 2^34, so dig needs no top clamp
      dig       = prod[33:18];
      if (dig < DIG_MIN) begin
         dig = DIG_MIN;
      end
      rsp_bad_in = s12_ff.bad;
      if (s12_ff.bad) begin
         // rejected request: everything but the flag reads zero
         rsp_frame_reg_in = '0;
         rsp_shift_in     = '0;
         rsp_exp_reg_in   = '0;
         rsp_code_in      = '0;
         rsp_dig_in       = '0;
         rsp_eff_frame_in = '0;
         rsp_eff_exp_in   = '0;
      end else begin
         rsp_frame_reg_in = s12_ff.frame_reg;
         rsp_shift_in     = s12_ff.shift;
         rsp_exp_reg_in   = s12_ff.exp_reg;
         rsp_code_in      = s12_ff.code;
         rsp_dig_in       = dig;
         rsp_eff_frame_in = s12_ff.eff_frame;
         rsp_eff_exp_in   = {7'b0, s12_ff.exp_reg} << s12_ff.shift;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bad_ff       <= rsp_bad_in;
      rsp_frame_reg_ff <= rsp_frame_reg_in;
      rsp_shift_ff     <= rsp_shift_in;
      rsp_exp_reg_ff   <= rsp_exp_reg_in;
      rsp_code_ff      <= rsp_code_in;
      rsp_dig_ff       <= rsp_dig_in;
      rsp_eff_frame_ff <= rsp_eff_frame_in;
      rsp_eff_exp_ff   <= rsp_eff_exp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s12_vld_ff;
      end
   end

   assign rsp_valid                    = rsp_valid_ff;
   assign rsp_bad_request              = rsp_bad_ff;
   assign rsp_frame_reg_value          = rsp_frame_reg_ff;
   assign rsp_frame_shift              = rsp_shift_ff;
   assign rsp_exposure_reg_value       = rsp_exp_reg_ff;
   assign rsp_analog_gain_code         = rsp_code_ff;
   assign rsp_digital_gain_code        = rsp_dig_ff;
   assign rsp_effective_frame_lines    = rsp_eff_frame_ff;
   assign rsp_effective_exposure_lines = rsp_eff_exp_ff;

endmodule

FILE: hw/rtl/segc_checker.sv
// segc_checker: port-level assertions for sensor_exposure_gain_calc_core
// depends on segc_pkg; bound to the core at the end of this file
module segc_checker
   import segc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic                  rsp_bad_request,
   input logic [REG_W-1:0]      rsp_frame_reg_value,
   input logic [SHIFT_W-1:0]    rsp_frame_shift,
   input logic [REG_W-1:0]      rsp_exposure_reg_value,
   input logic [CODE_W-1:0]     rsp_analog_gain_code,
   input logic [REG_W-1:0]      rsp_digital_gain_code,
   input logic [FRAME_W-1:0]    rsp_effective_frame_lines,
   input logic [FRAME_W-1:0]    rsp_effective_exposure_lines
);

   // every accepted request gives a result after the fixed latency
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request without result");

   // no result without a request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without request");

   // rejected request clears all other fields
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_request) |->
         (rsp_frame_reg_value == '0) && (rsp_frame_shift == '0) &&
         (rsp_exposure_reg_value == '0) && (rsp_analog_gain_code == '0) &&
         (rsp_digital_gain_code == '0) && (rsp_effective_frame_lines == '0) &&
         (rsp_effective_exposure_lines == '0))
      else $error("rejected result carries data");

   // accepted result stays within its code ranges and the frame fields agree
   a_good_ranges: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_request) |->
         (rsp_analog_gain_code >= CODE_MIN) && (rsp_analog_gain_code <= CODE_MAX) &&
         (rsp_digital_gain_code >= DIG_MIN) && (rsp_exposure_reg_value != '0) &&
         (rsp_effective_frame_lines == ({7'b0, rsp_frame_reg_value} << rsp_frame_shift)))
      else $error("result out of range");

endmodule

bind sensor_exposure_gain_calc_core segc_checker u_segc_checker (.*);
